// ===== hdl/ppu_pkg.sv =====
// Shared types and constants for the particle pool update block.
// No dependencies; every other file in hdl/ imports this package.
package ppu_pkg;

  // Field widths fixed by the item formats
  localparam int SLOT_W  = 10;
  localparam int FC_W    = 7;
  localparam int LIFE_W  = 8;
  localparam int FRAME_W = 8;

  // Pool depth default and frame count after reset
  localparam int             SLOTS_DEFAULT = 1024;
  localparam logic [FC_W-1:0] FC_RESET     = 7'd16;

  // Long-life frames: base + slot mod 18
  localparam int FRAME_BASE = 20;
  localparam int FRAME_MOD  = 18;
  // (s * 455) >> 13 for any 10-bit s is floor(s / 18), or one less
  localparam int MOD_RECIP  = 455;
  localparam int MOD_SHIFT  = 13;
  localparam int RECIP_W    = 9;
  localparam int PROD_W     = SLOT_W + RECIP_W;
  localparam int QUOT_W     = PROD_W - MOD_SHIFT;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_TICK = 2'd1,
    CMD_READ = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_ADD_WR,
    ST_TICK,
    ST_RD_MEM,
    ST_RD_CALC,
    ST_RD_FRAME,
    ST_EMIT
  } state_t;

  typedef struct packed {
    cmd_t               command;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic               long_life;
    logic signed [31:0] win_min_x;
    logic signed [31:0] win_max_x;
    logic signed [31:0] win_min_y;
    logic signed [31:0] win_max_y;
    logic [SLOT_W-1:0]  read_slot;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic [SLOT_W-1:0]  slot;
    logic               drawn;
    logic [FRAME_W-1:0] frame;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
  } out_item_t;

  // One pool slot as held in the slot memory
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic [LIFE_W-1:0]  life;
    logic               seen;
    logic               long_life;
  } entry_t;

  // Request to the frame calculator
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [LIFE_W-1:0] life;
    logic              long_life;
    logic [FC_W-1:0]   frame_count;
  } frame_req_t;

endpackage

// ===== hdl/ppu_frame.sv =====
// Sprite frame calculator for a read: registered between product and remainder, slot mod 18 by reciprocal.
// Depends on ppu_pkg (frame_req_t and frame constants).
module ppu_frame (
  input  logic                    clk,
  input  ppu_pkg::frame_req_t     req,
  output logic [ppu_pkg::FRAME_W-1:0] frame
);
  import ppu_pkg::*;

  logic [PROD_W-1:0]  prod;
  logic [FRAME_W-1:0] short_frame;
  logic [LIFE_W-1:0]  n_ext;
  logic [LIFE_W-1:0]  diff;

  logic [QUOT_W-1:0]  quot;
  logic [SLOT_W-1:0]  slot_q;
  logic               long_q;
  logic               dead_q;
  logic [FRAME_W-1:0] short_q;

  logic [SLOT_W:0]    rem_a;
  logic [SLOT_W:0]    rem_b;

  // Stage one: reciprocal product and short-life frame
  always_comb begin
    prod  = PROD_W'(req.slot) * PROD_W'(MOD_RECIP);
    n_ext = LIFE_W'(req.frame_count);
    if (req.life < n_ext) begin
      diff = n_ext - req.life;
    end else begin
      diff = req.life - n_ext;
    end
    if (req.frame_count == '0) begin
      short_frame = '0;
    end else if (diff >= n_ext) begin
      short_frame = FRAME_W'(n_ext - LIFE_W'(1));
    end else begin
      short_frame = FRAME_W'(diff);
    end
  end

  always_ff @(posedge clk) begin
    quot    <= prod[PROD_W-1:MOD_SHIFT];
    slot_q  <= req.slot;
    long_q  <= req.long_life;
    dead_q  <= (req.life == '0);
    short_q <= short_frame;
  end

  // Stage two: remainder with one correction step, then pick the frame
  always_comb begin
    rem_a = (SLOT_W+1)'(slot_q) - (SLOT_W+1)'(quot) * (SLOT_W+1)'(FRAME_MOD);
    if (rem_a >= (SLOT_W+1)'(FRAME_MOD)) begin
      rem_b = rem_a - (SLOT_W+1)'(FRAME_MOD);
    end else begin
      rem_b = rem_a;
    end
    if (dead_q) begin
      frame = '0;
    end else if (long_q) begin
      frame = FRAME_W'(FRAME_BASE) + FRAME_W'(rem_b);
    end else begin
      frame = short_q;
    end
  end

endmodule

// ===== hdl/particle_pool_update.sv =====
// Particle pool update: top level with the slot memory and the command sequencer.
// Depends on ppu_pkg and ppu_frame.
//
// Usage: one input channel (in_valid / in_stall / in_data) takes commands: add a
// particle, tick the whole pool, or read one slot. Each command yields exactly one
// result on the output channel (out_valid / out_stall / out_data). Only one
// command is worked on at a time; in_stall is high from the transfer until the
// result is handed to the output register.
// Work per command:
//   add while the pool is filling: a write to the next free slot
//   add on a full pool: a scan for a dead slot from the cursor to the last slot
//   tick: one slot per cycle through a three-stage update pipe over the filled slots
//   read: a memory read, then the frame calculator; a read of an unfilled slot
//     and an unused command go straight to the result
// The slot memory has one read and one write port. frame_count is written through
// cfg_write / cfg_data; the user writes it only while the block is idle, which the
// block does not enforce. Synchronous reset empties the pool (fill count and cursor
// to zero) and sets frame_count to 16; no clearing pass is needed. When the receiver
// stalls, the result holds in the output register and the next command may already
// run; its result waits in the sequencer until the output register frees up.
module particle_pool_update #(
  parameter int SLOTS = ppu_pkg::SLOTS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [ppu_pkg::FC_W-1:0]   cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ppu_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ppu_pkg::out_item_t         out_data
);
  import ppu_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  // Slot memory
  entry_t mem [SLOTS];
  entry_t rdata;
  entry_t wr_data;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;
  logic          we;

  // Control state
  state_t          state;
  state_t          state_next;
  logic [CW-1:0]   fill_count;
  logic [IW-1:0]   scan_cursor;
  logic [FC_W-1:0] frame_count;

  // Working registers of the current command
  in_item_t      item;
  out_item_t     res;
  out_item_t     res_next;
  logic [IW-1:0] cur;
  logic [IW-1:0] scan_k;
  logic          filling;
  logic          seen_keep;

  // Tick pipe
  logic [CW-1:0] ti;
  logic          v1;
  logic          v2;
  logic [IW-1:0] a1;
  logic [IW-1:0] a2;
  entry_t        e2;
  entry_t        e2_next;
  logic          alive2;
  logic          in_win;
  logic          tick_issue;

  logic          in_xfer;
  logic          emit_load;
  logic          read_ok;
  logic          pool_filling;
  logic [CW-1:0] fill_inc;

  frame_req_t          frame_req;
  logic [FRAME_W-1:0]  frame_value;

  assign in_xfer      = in_valid && !in_stall;
  assign emit_load    = (state == ST_EMIT) && (!out_valid || !out_stall);
  assign pool_filling = (fill_count < CW'(SLOTS));
  assign read_ok      = (32'(in_data.read_slot) < 32'(fill_count));
  assign tick_issue   = (state == ST_TICK) && (ti < fill_count);
  assign fill_inc     = fill_count + CW'(1);

  // Window test on the stepped position
  assign in_win = (e2.px >= item.win_min_x) && (e2.px <= item.win_max_x) &&
                  (e2.py >= item.win_min_y) && (e2.py <= item.win_max_y);

  // Frame calculator
  always_comb begin
    frame_req.slot        = item.read_slot;
    frame_req.life        = rdata.life;
    frame_req.long_life   = rdata.long_life;
    frame_req.frame_count = frame_count;
  end

  ppu_frame u_frame (
    .clk   (clk),
    .req   (frame_req),
    .frame (frame_value)
  );

  // Memory ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  // Sequencer: next state, memory addresses and write data
  always_comb begin
    state_next = state;
    in_stall   = (state != ST_IDLE);
    rd_addr    = '0;
    wr_addr    = a2;
    we         = 1'b0;
    wr_data    = e2;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_data.command)
            CMD_ADD:  state_next = pool_filling ? ST_ADD_WR : ST_SCAN_RD;
            CMD_TICK: state_next = ST_TICK;
            CMD_READ: state_next = read_ok ? ST_RD_MEM : ST_EMIT;
            default:  state_next = ST_EMIT;
          endcase
        end
      end
      ST_SCAN_RD: begin
        rd_addr    = scan_k;
        state_next = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (rdata.life == '0) begin
          state_next = ST_ADD_WR;
        end else if (scan_k == IW'(SLOTS - 1)) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_ADD_WR: begin
        we                = 1'b1;
        wr_addr           = cur;
        wr_data.px        = item.pos_x;
        wr_data.py        = item.pos_y;
        wr_data.vx        = item.vel_x;
        wr_data.vy        = item.vel_y;
        wr_data.life      = item.long_life ? {frame_count, 1'b0} : {1'b0, frame_count};
        wr_data.seen      = seen_keep;
        wr_data.long_life = item.long_life;
        state_next        = ST_EMIT;
      end
      ST_TICK: begin
        rd_addr = ti[IW-1:0];
        if (v2) begin
          // kill the particle unless it is still alive and inside the window
          we           = 1'b1;
          wr_data.seen = alive2 && in_win;
          wr_data.life = (alive2 && in_win) ? e2.life : '0;
        end
        if (!tick_issue && !v1 && !v2) begin
          state_next = ST_EMIT;
        end
      end
      ST_RD_MEM: begin
        rd_addr    = IW'(item.read_slot);
        state_next = ST_RD_CALC;
      end
      ST_RD_CALC:  state_next = ST_RD_FRAME;
      ST_RD_FRAME: state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Pool bookkeeping, configuration and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count  <= '0;
      scan_cursor <= '0;
      frame_count <= FC_RESET;
      out_valid   <= 1'b0;
      v1          <= 1'b0;
      v2          <= 1'b0;
    end else begin
      if (cfg_write) begin
        frame_count <= cfg_data;
      end
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      // after an add lands, advance the cursor, and the fill count while the pool fills
      if (state == ST_ADD_WR) begin
        if (filling) begin
          fill_count  <= fill_inc;
          scan_cursor <= (fill_inc == CW'(SLOTS)) ? '0 : fill_inc[IW-1:0];
        end else begin
          scan_cursor <= (cur == IW'(SLOTS - 1)) ? '0 : cur + IW'(1);
        end
      end
      // scan ran off the end: drop the particle, restart at slot zero
      if (state == ST_SCAN_CHK && rdata.life != '0 && scan_k == IW'(SLOTS - 1)) begin
        scan_cursor <= '0;
      end
      v1 <= tick_issue;
      v2 <= v1;
    end
  end

  // Step a live slot read by the tick pipe
  always_comb begin
    e2_next = rdata;
    if (rdata.life != '0) begin
      e2_next.px   = rdata.px + {{16{rdata.vx[15]}}, rdata.vx};
      e2_next.py   = rdata.py + {{16{rdata.vy[15]}}, rdata.vy};
      e2_next.life = rdata.life - LIFE_W'(1);
    end
  end

  // Build the result of the current command
  always_comb begin
    res_next = res;
    if (in_xfer) begin
      res_next      = '0;
      res_next.slot = (in_data.command == CMD_READ) ? in_data.read_slot : '0;
    end
    if (state == ST_ADD_WR) begin
      res_next.accepted = 1'b1;
      res_next.slot     = SLOT_W'(cur);
    end
    if (state == ST_RD_CALC) begin
      res_next.out_x = rdata.px;
      res_next.out_y = rdata.py;
      res_next.drawn = rdata.seen && (rdata.life != '0);
    end
    if (state == ST_RD_FRAME) begin
      res_next.frame = frame_value;
    end
  end

  // Command registers, tick pipe and result assembly
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item      <= in_data;
      cur       <= IW'(fill_count);
      filling   <= pool_filling;
      scan_k    <= scan_cursor;
      seen_keep <= 1'b0;
      ti        <= '0;
    end

    // scan step: hold the dead slot, or move on
    if (state == ST_SCAN_CHK) begin
      if (rdata.life == '0) begin
        cur       <= scan_k;
        seen_keep <= rdata.seen;
      end else begin
        scan_k <= scan_k + IW'(1);
      end
    end

    res <= res_next;

    // tick pipe: issue, step, then write back
    if (tick_issue) begin
      ti <= ti + CW'(1);
    end
    a1 <= ti[IW-1:0];
    a2 <= a1;
    e2 <= e2_next;
    alive2 <= (rdata.life != '0);

    if (emit_load) begin
      out_data <= res;
    end
  end

`ifndef SYNTHESIS
  // every transfer starts work: the sequencer leaves idle
  a_xfer_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state != ST_IDLE))
    else $error("input transfer did not start a command");

  // while the pool fills, the cursor tracks the fill count
  a_cursor_tracks_fill: assert property (@(posedge clk) disable iff (rst)
    pool_filling |-> (CW'(scan_cursor) == fill_count))
    else $error("scan cursor out of step with fill count");

  // tick write-back stays inside the filled part of the pool
  a_tick_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TICK && v2) |-> (CW'(a2) < fill_count))
    else $error("tick write-back beyond filled slots");

  // a result leaving the sequencer shows up at the output next cycle
  a_emit_reaches_out: assert property (@(posedge clk) disable iff (rst)
    emit_load |=> (out_valid && state == ST_IDLE))
    else $error("result did not reach the output register");
`endif

endmodule
